>>> design/rmst_pkg.sv
// Package for the range maximum segment tree.
// Holds the controller state type and the fixed field widths of the stream ports.
// Used by range_max_segment_tree_top and the testbench; depends on nothing.
package rmst_pkg;

    localparam int VALUE_W   = 31;
    localparam int POS_W     = 10;
    localparam int RANGE_W   = 11;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD_WR,
        S_UPD_RD,
        S_QRY_LO,
        S_QRY_HI,
        S_QRY_OUT
    } t_state;

endpackage

>>> design/rmst_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Holds the tree nodes of the segment tree; depends on nothing.
module rmst_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/range_max_segment_tree_top.sv
// Range maximum segment tree: one node RAM and the controller that walks it.
// The slave stream carries updates and queries, the master stream carries query maxima.
// Depends on rmst_pkg and rmst_ram.
//
// Usage:
// A transaction on the slave stream carries one item; tuser selects an update (0) or a
// range maximum query (1). An update writes one leaf and rebuilds its ancestors; it
// returns nothing. A query returns one transaction on the master stream holding the
// maximum over the half-open leaf range, or zero when the range is empty. Positions at
// or above LEAVES are ignored by updates, and query bounds saturate to LEAVES.
// After reset the node RAM is cleared one entry per cycle, all 2*LEAVES entries in turn,
// and no item is taken until that is done.
// One item is worked at a time. An update writes each node on its path to the root,
// reading the sibling between writes; a query walks up the tree level by level, with a
// low-bound step and a high-bound step per level, then a final output step. Both walks
// are paced by the single RAM read port and its registered read. The result sits in an
// output register: the next item is taken while it waits, and a query only stalls at
// its end if that register is still held by a stalled receiver.
module range_max_segment_tree_top #(
    parameter int LEAVES = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // leaf_position[9:0], leaf_value[40:10], range_low[51:41], range_high[62:52], zero
    input  logic [rmst_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // kind[0]
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // range_maximum[30:0], zero[31]
    output logic [rmst_pkg::M_TDATA_W-1:0]  o_m_tdata
);

    localparam int NODES = 2 * LEAVES;
    localparam int AW    = $clog2(NODES);
    localparam int IW    = $clog2(NODES + 1);
    localparam int VW    = rmst_pkg::VALUE_W;

    rmst_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [AW-1:0] r_k, n_k;
    logic [VW-1:0] r_cur, n_cur;
    logic [IW-1:0] r_lo, n_lo;
    logic [IW-1:0] r_hi, n_hi;
    logic [VW-1:0] r_best, n_best;
    logic          r_pend, n_pend;
    logic          r_out_valid, n_out_valid;
    logic [VW-1:0] r_out_data, n_out_data;

    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic [VW-1:0]             w_wdata;
    logic                      w_re;
    logic [AW-1:0]             w_raddr;
    logic [VW-1:0]             w_rdata;

    logic [rmst_pkg::POS_W-1:0]   w_pos;
    logic [VW-1:0]                w_value;
    logic [rmst_pkg::RANGE_W-1:0] w_range_low;
    logic [rmst_pkg::RANGE_W-1:0] w_range_high;
    logic                         w_pos_ok;
    logic [IW-1:0]                w_lo_sat;
    logic [IW-1:0]                w_hi_sat;
    logic [IW-1:0]                w_hi_dec;
    logic [VW-1:0]                w_acc;
    logic                         w_in_accept;

    assign w_pos        = i_s_tdata[9:0];
    assign w_value      = i_s_tdata[40:10];
    assign w_range_low  = i_s_tdata[51:41];
    assign w_range_high = i_s_tdata[62:52];

    assign w_pos_ok = 32'(w_pos) < 32'(LEAVES);
    assign w_lo_sat = (32'(w_range_low) > 32'(LEAVES)) ? IW'(LEAVES) : IW'(w_range_low);
    assign w_hi_sat = (32'(w_range_high) > 32'(LEAVES)) ? IW'(LEAVES) : IW'(w_range_high);
    assign w_hi_dec = r_hi - IW'(1);
    assign w_acc    = (r_pend && (w_rdata > r_best)) ? w_rdata : r_best;

    assign o_s_tready  = (r_state == rmst_pkg::S_IDLE);
    assign w_in_accept = i_s_tvalid && o_s_tready;

    rmst_ram #(
        .WIDTH (VW),
        .DEPTH (NODES)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmst_pkg::S_CLEAR;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_k        <= n_k;
        r_cur      <= n_cur;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_best     <= n_best;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_k         = r_k;
        n_cur       = r_cur;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_best      = r_best;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = '0;
        w_re        = 1'b0;
        w_raddr     = '0;
        case (r_state)
            rmst_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(NODES - 1)) begin
                    n_state = rmst_pkg::S_IDLE;
                end
            end
            rmst_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    if (i_s_tuser == rmst_pkg::KIND_QUERY) begin
                        n_lo    = w_lo_sat + IW'(LEAVES);
                        n_hi    = w_hi_sat + IW'(LEAVES);
                        n_best  = '0;
                        n_pend  = 1'b0;
                        n_state = rmst_pkg::S_QRY_LO;
                    end else if (w_pos_ok) begin
                        n_k     = AW'(LEAVES) + AW'(w_pos);
                        n_cur   = w_value;
                        n_state = rmst_pkg::S_UPD_WR;
                    end
                end
            end
            rmst_pkg::S_UPD_WR: begin
                w_we    = 1'b1;
                w_waddr = r_k;
                w_wdata = r_cur;
                if (r_k == AW'(1)) begin
                    n_state = rmst_pkg::S_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_k ^ AW'(1);
                    n_state = rmst_pkg::S_UPD_RD;
                end
            end
            rmst_pkg::S_UPD_RD: begin
                n_cur   = (w_rdata > r_cur) ? w_rdata : r_cur;
                n_k     = r_k >> 1;
                n_state = rmst_pkg::S_UPD_WR;
            end
            rmst_pkg::S_QRY_LO: begin
                n_best = w_acc;
                n_pend = 1'b0;
                if (r_lo >= r_hi) begin
                    n_state = rmst_pkg::S_QRY_OUT;
                end else begin
                    if (r_lo[0]) begin
                        w_re    = 1'b1;
                        w_raddr = r_lo[AW-1:0];
                        n_lo    = r_lo + IW'(1);
                        n_pend  = 1'b1;
                    end
                    n_state = rmst_pkg::S_QRY_HI;
                end
            end
            rmst_pkg::S_QRY_HI: begin
                n_best = w_acc;
                n_pend = 1'b0;
                if (r_hi[0]) begin
                    w_re    = 1'b1;
                    w_raddr = w_hi_dec[AW-1:0];
                    n_pend  = 1'b1;
                end
                n_lo    = r_lo >> 1;
                n_hi    = r_hi >> 1;
                n_state = rmst_pkg::S_QRY_LO;
            end
            rmst_pkg::S_QRY_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_best;
                    n_state     = rmst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rmst_pkg::S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_data};

`ifndef NO_ASSERTIONS
    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_re) |-> (w_waddr != w_raddr))
        else $error("read and write hit the same node in one cycle");

    a_lo_not_past_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rmst_pkg::S_QRY_HI) |-> (r_lo <= r_hi))
        else $error("query low bound passed the high bound");

    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == rmst_pkg::S_QRY_OUT))
        else $error("result appeared without a finished query");

    a_update_walk_above_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rmst_pkg::S_UPD_RD) |-> (r_k > AW'(1)))
        else $error("update walk read a sibling of the root");
`endif

endmodule

>>> verif/tb.sv
// Self-checking testbench for range_max_segment_tree_top: point updates and range maximum queries.
// A leaf-level scoreboard predicts each query maximum, checked against the master stream in order.
// Depends on rmst_pkg and the design sources only.
`timescale 1ns / 1ps

module tb;

    localparam int VALUE_W     = rmst_pkg::VALUE_W;
    localparam int POS_W       = rmst_pkg::POS_W;
    localparam int RANGE_W     = rmst_pkg::RANGE_W;
    localparam int S_TDATA_W   = rmst_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = rmst_pkg::M_TDATA_W;
    localparam int LEAVES      = 1024;
    localparam int STALL_LIMIT = 12000;
    localparam int RX_HOLD     = 400;

    typedef struct {
        logic               kind;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;
        bit                 drain_first;
    } t_tree_op;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    // leaf_position[9:0], leaf_value[40:10], range_low[51:41], range_high[62:52], zero
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    // kind[0]
    logic                 i_s_tuser = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // range_maximum[30:0], zero[31]
    logic [M_TDATA_W-1:0] o_m_tdata;

    t_tree_op             pending_ops[$];
    t_tree_op             op_in_flight;
    logic [VALUE_W-1:0]   maxima_due[$];
    logic [VALUE_W-1:0]   leaf_values[LEAVES];

    bit                   s_took = 1'b0;
    bit                   drain_next = 1'b0;
    bit                   hold_done = 1'b0;
    int                   burst_left = 8;
    int                   gap_left = 0;
    int                   hold_left = 0;
    int                   rx_mode = 0;
    int                   rx_count = 0;
    int                   quiet_cycles = 0;
    int                   total_ops = 0;
    int                   ops_taken = 0;
    int                   updates_taken = 0;
    int                   queries_taken = 0;
    int                   empty_queries = 0;
    int                   maxima_checked = 0;
    int                   errors = 0;

    range_max_segment_tree_top #(
        .LEAVES(LEAVES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        errors++;
    endtask

    function automatic logic [VALUE_W-1:0] range_peak(input logic [RANGE_W-1:0] lo,
                                                      input logic [RANGE_W-1:0] hi);
        int                 first;
        int                 stop;
        logic [VALUE_W-1:0] peak;
        first = (lo > LEAVES) ? LEAVES : int'(lo);
        stop  = (hi > LEAVES) ? LEAVES : int'(hi);
        peak  = '0;
        for (int i = first; i < stop; i++) begin
            if (leaf_values[i] > peak) peak = leaf_values[i];
        end
        return peak;
    endfunction

    task automatic add_update(input int pos, input logic [VALUE_W-1:0] value,
                              input int lo, input int hi);
        t_tree_op op;
        op.kind        = rmst_pkg::KIND_UPDATE;
        op.pos         = pos[POS_W-1:0];
        op.value       = value;
        op.lo          = lo[RANGE_W-1:0];
        op.hi          = hi[RANGE_W-1:0];
        op.drain_first = drain_next;
        drain_next     = 1'b0;
        pending_ops    = {pending_ops, op};
    endtask

    task automatic add_query(input int lo, input int hi,
                             input int pos, input logic [VALUE_W-1:0] value);
        t_tree_op op;
        op.kind        = rmst_pkg::KIND_QUERY;
        op.pos         = pos[POS_W-1:0];
        op.value       = value;
        op.lo          = lo[RANGE_W-1:0];
        op.hi          = hi[RANGE_W-1:0];
        op.drain_first = drain_next;
        drain_next     = 1'b0;
        pending_ops    = {pending_ops, op};
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return '0;
        if (pick == 1) return VALUE_W'($urandom_range(1, 15));
        if (pick == 2) return {VALUE_W{1'b1}};
        return VALUE_W'($urandom);
    endfunction

    task automatic add_random_ops(input int count);
        int lo;
        int hi;
        int pos;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 45) begin
                pos = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, LEAVES - 1);
                add_update(pos, random_value(), $urandom_range(0, 2047),
                           $urandom_range(0, 2047));
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        lo = $urandom_range(0, 2047);
                        hi = $urandom_range(0, 2047);
                    end
                    1: begin
                        lo = $urandom_range(0, LEAVES);
                        hi = lo;
                    end
                    2: begin
                        lo = 0;
                        hi = $urandom_range(LEAVES, 2047);
                    end
                    3, 4, 5: begin
                        lo = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63)
                                                         : $urandom_range(0, LEAVES - 1);
                        hi = lo + $urandom_range(1, 16);
                    end
                    default: begin
                        lo = $urandom_range(0, LEAVES - 1);
                        hi = $urandom_range(lo + 1, LEAVES);
                    end
                endcase
                add_query(lo, hi, $urandom_range(0, LEAVES - 1), VALUE_W'($urandom));
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !s_took) begin
        end else if (gap_left != 0) begin
            gap_left--;
            i_s_tvalid <= 1'b0;
        end else if (pending_ops.size() == 0 ||
                     (pending_ops[0].drain_first && maxima_due.size() != 0)) begin
            i_s_tvalid <= 1'b0;
        end else begin
            op_in_flight = pending_ops.pop_front();
            i_s_tvalid <= 1'b1;
            i_s_tuser  <= op_in_flight.kind;
            i_s_tdata  <= {1'b0, op_in_flight.hi, op_in_flight.lo,
                           op_in_flight.value, op_in_flight.pos};
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (!hold_done && maxima_checked >= 60) begin
            hold_done = 1'b1;
            hold_left = RX_HOLD;
            i_m_tready <= 1'b0;
        end else begin
            rx_count++;
            if (rx_count % 97 == 0) rx_mode = $urandom_range(0, 2);
            case (rx_mode)
                0:       i_m_tready <= 1'b1;
                1:       i_m_tready <= ($urandom_range(0, 1) == 0);
                default: i_m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        logic [VALUE_W-1:0] want;
        if (!i_rst_n) begin
            s_took <= 1'b0;
            foreach (leaf_values[i]) leaf_values[i] = '0;
        end else begin
            s_took <= i_s_tvalid && o_s_tready;
            if (i_s_tvalid && o_s_tready) begin
                ops_taken++;
                if (op_in_flight.kind == rmst_pkg::KIND_UPDATE) begin
                    updates_taken++;
                    leaf_values[op_in_flight.pos] = op_in_flight.value;
                end else begin
                    queries_taken++;
                    want = range_peak(op_in_flight.lo, op_in_flight.hi);
                    if (want == '0) empty_queries++;
                    maxima_due = {maxima_due, want};
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                if (maxima_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0h",
                                              o_m_tdata[VALUE_W-1:0]));
                end else begin
                    want = maxima_due.pop_front();
                    maxima_checked++;
                    if (o_m_tdata[VALUE_W-1:0] !== want) begin
                        report_mismatch($sformatf("range_maximum %0h, expected %0h",
                                                  o_m_tdata[VALUE_W-1:0], want));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles at %0t", STALL_LIMIT, $time);
            $display("range_max_segment_tree_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        add_query(0, LEAVES, 0, '0);
        add_update(0, {VALUE_W{1'b1}}, 2047, 2047);
        add_update(LEAVES - 1, 1, 0, 0);
        add_update(512, 31'h2AAAAAAA, 5, 900);
        add_update(341, 31'h55555555, 0, 0);
        add_update(682, '0, 1024, 1);
        add_query(0, LEAVES, 0, '0);
        add_query(1, LEAVES, 0, '0);
        add_query(LEAVES - 1, LEAVES, 0, '0);
        add_query(0, 1, LEAVES - 1, {VALUE_W{1'b1}});
        add_query(2047, 2047, 0, '0);
        add_query(LEAVES, 2047, 0, '0);
        add_query(5, 3, 0, '0);
        add_query(0, 0, 0, '0);
        add_query(0, 2047, 0, '0);
        add_query(512, 513, 0, '0);
        add_query(513, LEAVES - 1, 0, '0);
        add_update(0, '0, 0, 0);
        add_query(0, LEAVES, 0, '0);
        add_query(683, 2047, 0, '0);
        add_query(LEAVES - 1, LEAVES - 1, 0, '0);
        add_query(LEAVES - 2, LEAVES, 0, '0);
        drain_next = 1'b1;
        add_random_ops(350);
        drain_next = 1'b1;
        add_random_ops(350);
        total_ops = pending_ops.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_taken != total_ops || maxima_due.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("Run covered %0d updates and %0d queries (%0d with a zero maximum).",
                 updates_taken, queries_taken, empty_queries);
        $display("%0d query maxima checked, %0d mismatches.", maxima_checked, errors);
        if (errors == 0) begin
            $display("range_max_segment_tree_top regression: pass");
        end else begin
            $display("range_max_segment_tree_top regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/rmst_pkg.sv
design/rmst_ram.sv
design/range_max_segment_tree_top.sv
verif/tb.sv
